// ===== rtl/ts_pid_pkg.sv =====
package ts_pid_pkg;

  localparam int unsigned MEM_DEPTH = 384;
  localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] SYNC_BYTE = 8'h47;
  localparam logic [7:0] PACKET_BYTES = 8'd188;
  localparam logic [7:0] LAST_INDEX = 8'd187;
  localparam logic [2:0] MAX_EXTRA = 3'd4;
  localparam logic [MEM_AW-1:0] HALF_SIZE = MEM_AW'(192);

  localparam logic [15:0] SEARCH_LIMIT_RST = 16'd2048;
  localparam logic [15:0] SKIP_LIMIT_RST = 16'd6000;

  // command codes
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_DRAIN = 2'd1;
  localparam logic [1:0] CMD_EOS = 2'd2;

  // status codes
  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_SYNC_LOST = 2'd1;
  localparam logic [1:0] ST_SKIP_LIMIT = 2'd2;
  localparam logic [1:0] ST_EOS = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PSI_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_LIMIT = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic        first_byte;
    logic        last_byte;
    logic        unit_start;
    logic [3:0]  continuity;
    logic [47:0] packet_position;
  } out_word_t;

  typedef struct packed {
    logic [12:0] target_pid;
    logic        psi_mode;
    logic [2:0]  extra_bytes;
    logic [15:0] search_limit;
    logic [15:0] skip_limit;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic half, input logic [7:0] idx);
    mem_addr = MEM_AW'(idx) + (half ? HALF_SIZE : '0);
  endfunction

endpackage

// ===== rtl/ts_pid_store.sv =====
module ts_pid_store (
  input  logic                          clk,
  input  ts_pid_pkg::mem_wr_t           wr,
  input  logic [ts_pid_pkg::MEM_AW-1:0] rd_addr,
  output logic [7:0]                    rd_data
);

  logic [7:0] mem [0:ts_pid_pkg::MEM_DEPTH-1];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ts_pid_parse.sv =====
module ts_pid_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ts_pid_pkg::cfg_t              cfg,
  input  logic                          step,
  input  ts_pid_pkg::in_word_t          word,
  input  logic [7:0]                    rd_data,
  output ts_pid_pkg::mem_wr_t           wr,
  output logic [ts_pid_pkg::MEM_AW-1:0] rd_addr,
  output ts_pid_pkg::result_t           res
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'b01,
    PH_COLLECT = 2'b10
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [15:0] search_r, search_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [47:0] offset_r, offset_nxt;
  logic [7:0]  ptr_r, ptr_nxt;
  logic        fill_half_r, fill_half_nxt;

  logic [47:0] fill_pos_r, fill_pos_nxt;
  logic [7:0]  hb1_r, hb1_nxt, hb2_r, hb2_nxt, hb3_r, hb3_nxt, hb4_r, hb4_nxt;
  logic [7:0]  emit_start_r, emit_start_nxt;
  logic [3:0]  emit_cc_r, emit_cc_nxt;
  logic        emit_pusi_r, emit_pusi_nxt;
  logic [47:0] emit_pos_r, emit_pos_nxt;

  logic        have;
  logic        evt_hit;
  logic [1:0]  evt;
  logic [2:0]  extra_eff;
  logic [7:0]  extra_end;
  logic        search_hit;
  logic        skip_hit;
  logic [8:0]  start_w;
  logic        deliver;

  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    search_nxt     = search_r;
    skip_nxt       = skip_r;
    offset_nxt     = offset_r;
    ptr_nxt        = ptr_r;
    fill_half_nxt  = fill_half_r;
    fill_pos_nxt   = fill_pos_r;
    hb1_nxt        = hb1_r;
    hb2_nxt        = hb2_r;
    hb3_nxt        = hb3_r;
    hb4_nxt        = hb4_r;
    emit_start_nxt = emit_start_r;
    emit_cc_nxt    = emit_cc_r;
    emit_pusi_nxt  = emit_pusi_r;
    emit_pos_nxt   = emit_pos_r;
    wr             = '0;
    res            = '0;
    evt_hit        = 1'b0;
    evt            = ts_pid_pkg::ST_PAYLOAD;

    have       = (ptr_r != 8'd0) && (ptr_r < ts_pid_pkg::PACKET_BYTES);
    extra_eff  = (cfg.extra_bytes > ts_pid_pkg::MAX_EXTRA) ? ts_pid_pkg::MAX_EXTRA
                                                           : cfg.extra_bytes;
    extra_end  = ts_pid_pkg::PACKET_BYTES + 8'(extra_eff);
    search_hit = search_r >= cfg.search_limit;
    skip_hit   = skip_r >= cfg.skip_limit;
    start_w    = (hb3_r[5] || cfg.psi_mode) ? (9'd5 + 9'(hb4_r)) : 9'd4;
    deliver    = ({hb1_r[4:0], hb2_r} == cfg.target_pid) && hb3_r[4] &&
                 (start_w < 9'(ts_pid_pkg::PACKET_BYTES));

    if (step) begin
      ptr_nxt = have ? ((ptr_r == ts_pid_pkg::LAST_INDEX) ? 8'd0 : ptr_r + 8'd1) : 8'd0;
      case (word.command)
        ts_pid_pkg::CMD_DATA: begin
          offset_nxt = offset_r + 48'd1;
          if (phase_r != PH_COLLECT) begin
            if (word.in_byte == ts_pid_pkg::SYNC_BYTE) begin
              phase_nxt    = PH_COLLECT;
              idx_nxt      = 8'd1;
              fill_pos_nxt = offset_r;
            end else if (search_hit) begin
              search_nxt = '0;
              skip_nxt   = '0;
              phase_nxt  = PH_HUNT;
              idx_nxt    = '0;
              evt_hit    = 1'b1;
              evt        = ts_pid_pkg::ST_SYNC_LOST;
            end else begin
              search_nxt = search_r + 16'd1;
            end
          end else if (idx_r < ts_pid_pkg::PACKET_BYTES) begin
            wr.en   = 1'b1;
            wr.addr = ts_pid_pkg::mem_addr(fill_half_r, idx_r);
            wr.data = word.in_byte;
            idx_nxt = idx_r + 8'd1;
            if (idx_r == 8'd1) hb1_nxt = word.in_byte;
            if (idx_r == 8'd2) hb2_nxt = word.in_byte;
            if (idx_r == 8'd3) hb3_nxt = word.in_byte;
            if (idx_r == 8'd4) hb4_nxt = word.in_byte;
          end else if (idx_r < extra_end) begin
            idx_nxt = idx_r + 8'd1;
          end else if (word.in_byte == ts_pid_pkg::SYNC_BYTE) begin
            if (skip_hit) begin
              search_nxt = '0;
              skip_nxt   = '0;
              evt_hit    = 1'b1;
              evt        = ts_pid_pkg::ST_SKIP_LIMIT;
            end else begin
              skip_nxt   = skip_r + 16'd1;
              search_nxt = '0;
              if (deliver) begin
                emit_start_nxt = start_w[7:0];
                emit_cc_nxt    = hb3_r[3:0];
                emit_pusi_nxt  = hb1_r[6];
                emit_pos_nxt   = fill_pos_r;
                ptr_nxt        = start_w[7:0];
                fill_half_nxt  = ~fill_half_r;
                skip_nxt       = '0;
              end
            end
            phase_nxt    = PH_COLLECT;
            idx_nxt      = 8'd1;
            fill_pos_nxt = offset_r;
          end else begin
            phase_nxt = PH_HUNT;
            idx_nxt   = '0;
            if (search_hit) begin
              search_nxt = '0;
              skip_nxt   = '0;
              evt_hit    = 1'b1;
              evt        = ts_pid_pkg::ST_SYNC_LOST;
            end else begin
              search_nxt = search_r + 16'd1;
            end
          end
        end
        ts_pid_pkg::CMD_EOS: begin
          search_nxt = '0;
          skip_nxt   = '0;
          phase_nxt  = PH_HUNT;
          idx_nxt    = '0;
          evt_hit    = 1'b1;
          evt        = ts_pid_pkg::ST_EOS;
        end
        default: begin
        end
      endcase

      if (evt_hit) begin
        ptr_nxt          = 8'd0;
        res.valid        = 1'b1;
        res.word.status  = evt;
      end else if (have) begin
        res.valid                = 1'b1;
        res.word.status          = ts_pid_pkg::ST_PAYLOAD;
        res.word.out_byte        = rd_data;
        res.word.first_byte      = (ptr_r == emit_start_r);
        res.word.last_byte       = (ptr_r == ts_pid_pkg::LAST_INDEX);
        res.word.unit_start      = emit_pusi_r;
        res.word.continuity      = emit_cc_r;
        res.word.packet_position = emit_pos_r;
      end
    end

    // prefetch the byte that the next word will emit
    rd_addr = ts_pid_pkg::mem_addr(~fill_half_nxt, ptr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      idx_r       <= '0;
      search_r    <= '0;
      skip_r      <= '0;
      offset_r    <= '0;
      ptr_r       <= '0;
      fill_half_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      search_r    <= search_nxt;
      skip_r      <= skip_nxt;
      offset_r    <= offset_nxt;
      ptr_r       <= ptr_nxt;
      fill_half_r <= fill_half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_pos_r   <= fill_pos_nxt;
    hb1_r        <= hb1_nxt;
    hb2_r        <= hb2_nxt;
    hb3_r        <= hb3_nxt;
    hb4_r        <= hb4_nxt;
    emit_start_r <= emit_start_nxt;
    emit_cc_r    <= emit_cc_nxt;
    emit_pusi_r  <= emit_pusi_nxt;
    emit_pos_r   <= emit_pos_nxt;
  end

endmodule

// ===== rtl/ts_packet_pid_filter_core.sv =====
// Transport-stream PID filter. Takes one stream word per clock (data byte, drain tick or end of
// stream) unless the receiver stalls, and returns at most one result word per input word: a
// payload byte of a confirmed packet on the configured PID, or a sync-lost, skip-limit or
// end-of-stream status. Sustained rate is one input word per clock while out_stall is low. A
// result word passes the input register and the single-pass parse step into the result register.
// Packets are collected into one half of a 384-byte double buffer while the previous packet's
// payload is read from the other half; the next byte's read is prefetched, so the memory port
// never limits the rate. No byte is emitted before it is written: no clearing after reset is needed.
// The user must write configuration only while the block idles; the block does not enforce it.
module ts_packet_pid_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ts_pid_pkg::in_word_t              in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ts_pid_pkg::out_word_t             out_word,
  input  logic                              cfg_we,
  input  logic [ts_pid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ts_pid_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ts_pid_pkg::cfg_t                cfg_r;
  logic                            in_valid_r;
  ts_pid_pkg::in_word_t            in_word_r;
  logic                            out_valid_r;
  ts_pid_pkg::out_word_t           out_word_r;
  logic                            go;
  ts_pid_pkg::mem_wr_t             wr;
  logic [ts_pid_pkg::MEM_AW-1:0]   rd_addr;
  logic [7:0]                      rd_data;
  ts_pid_pkg::result_t             res;

  assign go       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_pid   <= '0;
      cfg_r.psi_mode     <= 1'b0;
      cfg_r.extra_bytes  <= '0;
      cfg_r.search_limit <= ts_pid_pkg::SEARCH_LIMIT_RST;
      cfg_r.skip_limit   <= ts_pid_pkg::SKIP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ts_pid_pkg::REG_TARGET_PID:   cfg_r.target_pid   <= cfg_wdata[12:0];
        ts_pid_pkg::REG_PSI_MODE:     cfg_r.psi_mode     <= cfg_wdata[0];
        ts_pid_pkg::REG_EXTRA_BYTES:  cfg_r.extra_bytes  <= cfg_wdata[2:0];
        ts_pid_pkg::REG_SEARCH_LIMIT: cfg_r.search_limit <= cfg_wdata;
        ts_pid_pkg::REG_SKIP_LIMIT:   cfg_r.skip_limit   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.valid) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  ts_pid_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step    (go),
    .word    (in_word_r),
    .rd_data (rd_data),
    .wr      (wr),
    .rd_addr (rd_addr),
    .res     (res)
  );

  ts_pid_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef ASSERT_OFF
  a_status_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status != ts_pid_pkg::ST_PAYLOAD)) |->
      (out_word.out_byte == 8'd0) && !out_word.first_byte && !out_word.last_byte &&
      !out_word.unit_start && (out_word.continuity == 4'd0) &&
      (out_word.packet_position == 48'd0))
    else $error("status word carries nonzero payload fields");

  a_stall_only_on_backup: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register can drain");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== tb/pid_filter_checker.sv =====
`timescale 1ns / 1ps

module pid_filter_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  ts_pid_pkg::in_word_t              in_word,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  ts_pid_pkg::out_word_t             out_word,
  input  logic                              cfg_we,
  input  logic [ts_pid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ts_pid_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                error_count,
  output int                                pending_count
);

  ts_pid_pkg::cfg_t      regs;
  logic [7:0]            pkt_mem [0:ts_pid_pkg::MEM_DEPTH-1];
  logic                  collecting;
  logic                  fill_half;
  int unsigned           byte_idx;
  int unsigned           search_cnt;
  int unsigned           skip_cnt;
  int unsigned           emit_ptr;
  logic [47:0]           stream_pos;
  logic [47:0]           hdr_pos [0:1];
  logic [3:0]            hdr_cc [0:1];
  logic                  hdr_pusi [0:1];
  int unsigned           hdr_start [0:1];
  ts_pid_pkg::out_word_t expected_words [$];

  function automatic logic [ts_pid_pkg::MEM_AW-1:0] slot(input logic h, input int unsigned i);
    return ts_pid_pkg::mem_addr(h, 8'(i));
  endfunction

  function automatic void clear_counters();
    search_cnt = 0;
    skip_cnt = 0;
    collecting = 1'b0;
    byte_idx = 0;
  endfunction

  // returns 1 when the search limit trips
  function automatic bit count_non_sync();
    if (search_cnt >= 32'(regs.search_limit)) begin
      clear_counters();
      return 1'b1;
    end
    search_cnt++;
    return 1'b0;
  endfunction

  function automatic void start_packet(input logic [47:0] pos);
    collecting = 1'b1;
    byte_idx = 1;
    pkt_mem[slot(fill_half, 0)] = ts_pid_pkg::SYNC_BYTE;
    hdr_pos[fill_half] = pos;
    hdr_cc[fill_half] = '0;
    hdr_pusi[fill_half] = 1'b0;
    hdr_start[fill_half] = 0;
  endfunction

  // ST_PAYLOAD as return value means no status word
  function automatic logic [1:0] confirm_packet(input logic [47:0] pos);
    int unsigned first_idx;
    logic [12:0] pid;
    logic [1:0]  afc;
    if (skip_cnt >= 32'(regs.skip_limit)) begin
      clear_counters();
      start_packet(pos);
      return ts_pid_pkg::ST_SKIP_LIMIT;
    end
    skip_cnt++;
    search_cnt = 0;
    pid = {pkt_mem[slot(fill_half, 1)][4:0], pkt_mem[slot(fill_half, 2)]};
    afc = pkt_mem[slot(fill_half, 3)][5:4];
    if (pid == regs.target_pid && afc[0]) begin
      first_idx = 4;
      if (afc[1] || regs.psi_mode) first_idx = 5 + 32'(pkt_mem[slot(fill_half, 4)]);
      if (first_idx < 32'(ts_pid_pkg::PACKET_BYTES)) begin
        hdr_cc[fill_half] = pkt_mem[slot(fill_half, 3)][3:0];
        hdr_pusi[fill_half] = pkt_mem[slot(fill_half, 1)][6];
        hdr_start[fill_half] = first_idx;
        emit_ptr = first_idx;
        fill_half = ~fill_half;
        skip_cnt = 0;
      end
    end
    start_packet(pos);
    return ts_pid_pkg::ST_PAYLOAD;
  endfunction

  function automatic void filter_step(input ts_pid_pkg::in_word_t w);
    ts_pid_pkg::out_word_t res;
    bit                    have;
    logic [1:0]            ev;
    logic                  h;
    logic [47:0]           pos;
    int unsigned           extra;
    res = '0;
    have = 1'b0;
    ev = ts_pid_pkg::ST_PAYLOAD;
    if (emit_ptr != 0 && emit_ptr < 32'(ts_pid_pkg::PACKET_BYTES)) begin
      h = ~fill_half;
      have = 1'b1;
      res.status = ts_pid_pkg::ST_PAYLOAD;
      res.out_byte = pkt_mem[slot(h, emit_ptr)];
      res.first_byte = (emit_ptr == hdr_start[h]);
      res.last_byte = (emit_ptr == 32'(ts_pid_pkg::LAST_INDEX));
      res.unit_start = hdr_pusi[h];
      res.continuity = hdr_cc[h];
      res.packet_position = hdr_pos[h];
      emit_ptr = res.last_byte ? 0 : emit_ptr + 1;
    end else begin
      emit_ptr = 0;
    end

    if (w.command == ts_pid_pkg::CMD_DATA) begin
      pos = stream_pos;
      stream_pos = stream_pos + 48'd1;
      if (!collecting) begin
        if (w.in_byte == ts_pid_pkg::SYNC_BYTE) start_packet(pos);
        else if (count_non_sync()) ev = ts_pid_pkg::ST_SYNC_LOST;
      end else begin
        extra = 32'((regs.extra_bytes > ts_pid_pkg::MAX_EXTRA) ? ts_pid_pkg::MAX_EXTRA
                                                                : regs.extra_bytes);
        if (byte_idx < 32'(ts_pid_pkg::PACKET_BYTES)) begin
          pkt_mem[slot(fill_half, byte_idx)] = w.in_byte;
          byte_idx++;
        end else if (byte_idx < 32'(ts_pid_pkg::PACKET_BYTES) + extra) begin
          byte_idx++;
        end else if (w.in_byte == ts_pid_pkg::SYNC_BYTE) begin
          ev = confirm_packet(pos);
        end else begin
          collecting = 1'b0;
          byte_idx = 0;
          if (count_non_sync()) ev = ts_pid_pkg::ST_SYNC_LOST;
        end
      end
    end else if (w.command == ts_pid_pkg::CMD_EOS) begin
      clear_counters();
      ev = ts_pid_pkg::ST_EOS;
    end

    if (ev != ts_pid_pkg::ST_PAYLOAD) begin
      emit_ptr = 0;
      res = '0;
      res.status = ev;
      expected_words.push_back(res);
    end else if (have) begin
      expected_words.push_back(res);
    end
  endfunction

  function automatic void write_reg(input logic [ts_pid_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [ts_pid_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ts_pid_pkg::REG_TARGET_PID:   regs.target_pid = data[12:0];
      ts_pid_pkg::REG_PSI_MODE:     regs.psi_mode = data[0];
      ts_pid_pkg::REG_EXTRA_BYTES:  regs.extra_bytes = data[2:0];
      ts_pid_pkg::REG_SEARCH_LIMIT: regs.search_limit = data;
      ts_pid_pkg::REG_SKIP_LIMIT:   regs.skip_limit = data;
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    regs = '0;
    regs.search_limit = ts_pid_pkg::SEARCH_LIMIT_RST;
    regs.skip_limit = ts_pid_pkg::SKIP_LIMIT_RST;
    clear_counters();
    fill_half = 1'b0;
    emit_ptr = 0;
    stream_pos = '0;
    hdr_pos = '{default: '0};
    hdr_cc = '{default: '0};
    hdr_pusi = '{default: 1'b0};
    hdr_start = '{default: 0};
    expected_words.delete();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch on %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic check_result(input ts_pid_pkg::out_word_t got);
    ts_pid_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected word, status", 64'(got.status), 64'(0));
      return;
    end
    want = expected_words.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", 64'(got.out_byte), 64'(want.out_byte));
    if (got.first_byte !== want.first_byte)
      report_mismatch("first_byte", 64'(got.first_byte), 64'(want.first_byte));
    if (got.last_byte !== want.last_byte)
      report_mismatch("last_byte", 64'(got.last_byte), 64'(want.last_byte));
    if (got.unit_start !== want.unit_start)
      report_mismatch("unit_start", 64'(got.unit_start), 64'(want.unit_start));
    if (got.continuity !== want.continuity)
      report_mismatch("continuity", 64'(got.continuity), 64'(want.continuity));
    if (got.packet_position !== want.packet_position)
      report_mismatch("packet_position", 64'(got.packet_position),
                      64'(want.packet_position));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_valid && !out_stall) check_result(out_word);
      if (in_valid && !in_stall) filter_step(in_word);
      if (cfg_we) write_reg(cfg_index, cfg_wdata);
    end
    pending_count = expected_words.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned RANDOM_WORDS = 300;
  localparam int unsigned PHASES = 3;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [ts_pid_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  ts_pid_pkg::in_word_t              in_word;
  logic                              out_valid;
  logic                              out_stall;
  ts_pid_pkg::out_word_t             out_word;
  logic                              cfg_we;
  logic [ts_pid_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ts_pid_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                                error_count;
  int                                pending_count;

  int unsigned sent_words = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  logic [12:0] cur_pid;
  int unsigned cur_trailer;

  ts_packet_pid_filter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pid_filter_checker filter_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode = 0;
    mode_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served < holds_asked) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ((mode_left % 4) < 2);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic put(input logic [1:0] cmd, input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= '{command: cmd, in_byte: data};
    do @(posedge clk); while (in_stall);
    sent_words++;
  endtask

  task automatic put_byte(input logic [7:0] data);
    put(ts_pid_pkg::CMD_DATA, data);
  endtask

  task automatic send_packet(input logic [12:0] pid, input logic [1:0] afc, input logic pusi,
                             input logic [3:0] cc, input logic [7:0] field_len,
                             input int unsigned trailer);
    logic [7:0] b1;
    logic [7:0] b3;
    b1 = {1'($urandom), pusi, 1'($urandom), pid[12:8]};
    b3 = {2'($urandom), afc, cc};
    put_byte(ts_pid_pkg::SYNC_BYTE);
    put_byte(b1);
    put_byte(pid[7:0]);
    put_byte(b3);
    put_byte(field_len);
    repeat (183) put_byte(8'($urandom));
    repeat (trailer) put_byte(8'($urandom));
  endtask

  task automatic rand_packet();
    logic [12:0] pid;
    logic [1:0]  afc;
    logic [7:0]  flen;
    int unsigned trailer;
    pid = ($urandom_range(0, 9) < 7) ? cur_pid : 13'($urandom);
    case ($urandom_range(0, 5))
      0: afc = 2'b00;
      1: afc = 2'b10;
      2, 3: afc = 2'b11;
      default: afc = 2'b01;
    endcase
    flen = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
    trailer = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) : cur_trailer;
    send_packet(pid, afc, 1'($urandom), 4'($urandom), flen, trailer);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ts_pid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ts_pid_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic set_config(input logic [12:0] pid, input logic psi, input logic [2:0] extra,
                            input logic [15:0] s_lim, input logic [15:0] k_lim);
    settle();
    write_reg(ts_pid_pkg::REG_TARGET_PID, 16'(pid));
    write_reg(ts_pid_pkg::REG_PSI_MODE, 16'(psi));
    write_reg(ts_pid_pkg::REG_EXTRA_BYTES, 16'(extra));
    write_reg(ts_pid_pkg::REG_SEARCH_LIMIT, s_lim);
    write_reg(ts_pid_pkg::REG_SKIP_LIMIT, k_lim);
    write_reg(REG_UNMAPPED, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_pid = pid;
    cur_trailer = 32'((extra > ts_pid_pkg::MAX_EXTRA) ? ts_pid_pkg::MAX_EXTRA : extra);
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned pick;
    logic [15:0] s_lim;
    logic [15:0] k_lim;
    logic [12:0] pid;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cur_pid = '0;
    cur_trailer = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: pid 0, no trailer
    put(CMD_SPARE, 8'hFF);
    put(ts_pid_pkg::CMD_DRAIN, 8'h00);
    put_byte(8'h00);
    put_byte(8'hFF);
    put(ts_pid_pkg::CMD_EOS, 8'hA5);
    send_packet(13'd0, 2'b11, 1'b0, 4'h6, 8'd183, 0);
    send_packet(13'd0, 2'b11, 1'b1, 4'h5, 8'd182, 0);
    holds_asked++;
    send_packet(13'd0, 2'b01, 1'b1, 4'hF, 8'h00, 0);
    // delivered packet cut by end of stream
    put_byte(ts_pid_pkg::SYNC_BYTE);
    repeat (20) put(ts_pid_pkg::CMD_DRAIN, 8'h00);
    put(ts_pid_pkg::CMD_EOS, 8'h00);

    set_config(13'h1FFF, 1'b1, 3'd4, 16'd0, 16'hFFFF);
    send_packet(13'h1FFF, 2'b01, 1'b0, 4'h2, 8'd0, 4);
    put_byte(ts_pid_pkg::SYNC_BYTE);
    repeat (10) put(ts_pid_pkg::CMD_DRAIN, 8'h00);
    put(ts_pid_pkg::CMD_EOS, 8'h00);
    put_byte(8'h00);
    put_byte(8'h01);

    set_config(13'd0, 1'b0, 3'd7, 16'hFFFF, 16'd0);
    send_packet(13'd0, 2'b01, 1'b1, 4'h5, 8'd0, 4);
    put_byte(ts_pid_pkg::SYNC_BYTE);
    put(ts_pid_pkg::CMD_EOS, 8'h00);

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: s_lim = 16'd0;
        1: s_lim = 16'($urandom_range(1, 30));
        2: s_lim = ts_pid_pkg::SEARCH_LIMIT_RST;
        default: s_lim = 16'hFFFF;
      endcase
      case ($urandom_range(0, 3))
        0: k_lim = 16'd0;
        1: k_lim = 16'($urandom_range(1, 4));
        2: k_lim = ts_pid_pkg::SKIP_LIMIT_RST;
        default: k_lim = 16'hFFFF;
      endcase
      case ($urandom_range(0, 2))
        0: pid = 13'd0;
        1: pid = 13'h1FFF;
        default: pid = 13'($urandom);
      endcase
      set_config(pid, 1'($urandom), 3'($urandom), s_lim, k_lim);
      phase_end = sent_words + RANDOM_WORDS / PHASES;
      while (sent_words < phase_end) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0) holds_asked++;
        if (pick < 75) begin
          rand_packet();
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 8)) put_byte(8'($urandom));
        end else if (pick < 92) begin
          repeat ($urandom_range(1, 6))
            put($urandom_range(0, 1) ? ts_pid_pkg::CMD_DRAIN : CMD_SPARE, 8'($urandom));
        end else if (pick < 96) begin
          put_byte(ts_pid_pkg::SYNC_BYTE);
          repeat ($urandom_range(1, 150)) put_byte(8'($urandom));
        end else begin
          put(ts_pid_pkg::CMD_EOS, 8'($urandom));
        end
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== ts_packet_pid_filter_core.f =====
rtl/ts_pid_pkg.sv
rtl/ts_pid_store.sv
rtl/ts_pid_parse.sv
rtl/ts_packet_pid_filter_core.sv
tb/pid_filter_checker.sv
tb/tb.sv
